// ===== hdl/lsc_pkg.sv =====
package lsc_pkg;

    // Fixed field widths of the ports
    localparam int OP_W     = 3;
    localparam int LIGHT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int MASK_W   = 8;

    // Default configuration
    localparam int LSC_NUM_SLOTS     = 8;
    localparam int LSC_LIGHT_ID_BITS = 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_DEFINE      = 3'd0;
    localparam logic [OP_W-1:0] OP_ENABLE      = 3'd1;
    localparam logic [OP_W-1:0] OP_DISABLE     = 3'd2;
    localparam logic [OP_W-1:0] OP_DISABLE_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_INVAL_ALL   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ENABLED = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } lsc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } lsc_stat_t;

endpackage

// ===== hdl/lsc_ctrl.sv =====
module lsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lsc_pkg::lsc_stat_t stat,
    output lsc_pkg::lsc_cmd_t  cmd
);
    import lsc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = stat.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/lsc_dp.sv =====
module lsc_dp #(
    parameter int NUM_SLOTS     = lsc_pkg::LSC_NUM_SLOTS,
    parameter int LIGHT_ID_BITS = lsc_pkg::LSC_LIGHT_ID_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lsc_pkg::OP_W-1:0]      opcode,
    input  logic [lsc_pkg::LIGHT_W-1:0]   light_number,
    input  lsc_pkg::lsc_cmd_t             cmd,
    output lsc_pkg::lsc_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lsc_pkg::STATUS_W-1:0]  status,
    output logic [lsc_pkg::SLOT_W-1:0]    slot,
    output logic                          hit,
    output logic                          load_params,
    output logic                          turn_on,
    output logic [lsc_pkg::MASK_W-1:0]    disabled_mask
);
    import lsc_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = LIGHT_ID_BITS + 1;

    // Slot state
    logic [NUM_SLOTS-1:0]     valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]     en_reg, en_next;
    logic [NUM_SLOTS-1:0]     dirty_reg, dirty_next;
    logic [LIGHT_ID_BITS-1:0] light_reg [NUM_SLOTS];
    logic [LIGHT_ID_BITS-1:0] light_next [NUM_SLOTS];
    logic [31:0]              age_reg [NUM_SLOTS];
    logic [31:0]              age_next [NUM_SLOTS];
    logic [31:0]              time_reg, time_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // Current transaction
    logic [OP_W-1:0]          op_reg, op_next;
    logic [LIGHT_ID_BITS-1:0] num_reg, num_next;

    // Age scan
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [31:0]              best_age_reg, best_age_next;
    logic                     best_vld_reg, best_vld_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic                     hit_reg, hit_next;
    logic                     load_reg, load_next;
    logic                     on_reg, on_next;
    logic [MASK_W-1:0]        mask_reg, mask_next;

    // Associative lookup
    logic [NUM_SLOTS-1:0]     match_vec;
    logic [NUM_SLOTS-1:0]     match_en_vec;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         dis_idx;
    logic                     defined;

    always_comb
    begin
        hit_idx = '0;
        dis_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match_vec[i]    = valid_reg[i] && (light_reg[i] == num_reg);
            match_en_vec[i] = match_vec[i] && en_reg[i];
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (match_en_vec[i])
            begin
                dis_idx = IDX_W'(i);
            end
        end
    end

    assign defined        = ({1'b0, num_reg} < cnt_reg);
    assign stat.need_scan = (op_reg == OP_ENABLE) && defined && (match_vec == '0);
    assign stat.scan_last = (scan_idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        valid_next     = valid_reg;
        en_next        = en_reg;
        dirty_next     = dirty_reg;
        light_next     = light_reg;
        age_next       = age_reg;
        time_next      = time_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        num_next       = num_reg;
        scan_idx_next  = scan_idx_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        best_vld_next  = best_vld_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        load_next      = load_reg;
        on_next        = on_reg;
        mask_next      = mask_reg;

        if (cmd.capture)
        begin
            op_next       = opcode;
            num_next      = LIGHT_ID_BITS'(light_number);
            scan_idx_next = '0;
            best_vld_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            // strict less-than keeps the lowest index on equal ages
            if (!en_reg[scan_idx_reg] &&
                (!best_vld_reg || (age_reg[scan_idx_reg] < best_age_reg)))
            begin
                best_vld_next = 1'b1;
                best_idx_next = scan_idx_reg;
                best_age_next = age_reg[scan_idx_reg];
            end
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            slot_next      = '0;
            hit_next       = 1'b0;
            load_next      = 1'b0;
            on_next        = 1'b0;
            mask_next      = '0;
            case (op_reg)
                OP_DEFINE:
                begin
                    if (defined)
                    begin
                        dirty_next = dirty_reg | match_vec;
                    end
                    else
                    begin
                        cnt_next = {1'b0, num_reg} + CNT_W'(1);
                    end
                end
                OP_ENABLE:
                begin
                    if (!defined)
                    begin
                        status_next = ST_TOO_BIG;
                    end
                    else if (match_vec != '0)
                    begin
                        hit_next            = 1'b1;
                        slot_next           = SLOT_W'(hit_idx);
                        load_next           = dirty_reg[hit_idx];
                        on_next             = !en_reg[hit_idx];
                        dirty_next[hit_idx] = 1'b0;
                        en_next[hit_idx]    = 1'b1;
                    end
                    else if (!best_vld_reg)
                    begin
                        status_next = ST_NO_SLOT;
                    end
                    else
                    begin
                        // fresh allocation: always dirty, always switched on
                        slot_next                  = SLOT_W'(best_idx_reg);
                        load_next                  = 1'b1;
                        on_next                    = 1'b1;
                        age_next[best_idx_reg]     = time_reg;
                        light_next[best_idx_reg]   = num_reg;
                        valid_next[best_idx_reg]   = 1'b1;
                        dirty_next[best_idx_reg]   = 1'b0;
                        en_next[best_idx_reg]      = 1'b1;
                        time_next                  = time_reg + 32'd1;
                    end
                end
                OP_DISABLE:
                begin
                    if (match_en_vec == '0)
                    begin
                        status_next = ST_NOT_ENABLED;
                    end
                    else
                    begin
                        slot_next        = SLOT_W'(dis_idx);
                        en_next[dis_idx] = 1'b0;
                        mask_next        = MASK_W'(NUM_SLOTS'(1) << dis_idx);
                    end
                end
                OP_DISABLE_ALL:
                begin
                    mask_next = MASK_W'(en_reg);
                    en_next   = '0;
                end
                OP_INVAL_ALL:
                begin
                    dirty_next = '1;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            en_reg        <= '0;
            dirty_reg     <= '0;
            time_reg      <= 32'd1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            en_reg        <= en_next;
            dirty_reg     <= dirty_next;
            time_reg      <= time_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            age_reg       <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        light_reg    <= light_next;
        op_reg       <= op_next;
        num_reg      <= num_next;
        scan_idx_reg <= scan_idx_next;
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
        best_vld_reg <= best_vld_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        load_reg     <= load_next;
        on_reg       <= on_next;
        mask_reg     <= mask_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign hit           = hit_reg;
    assign load_params   = load_reg;
    assign turn_on       = on_reg;
    assign disabled_mask = mask_reg;

endmodule

// ===== hdl/light_slot_cache_top.sv =====
// Light slot cache: maps light numbers onto NUM_SLOTS hardware light slots and
// returns exactly one result transaction per input transaction (define, enable,
// disable, disable all, invalidate all). The block works on one transaction at
// a time and holds in_stall high while busy. Enable that misses in the cache
// walks the slot ages through the datapath one slot per cycle to find the
// oldest disabled slot, between lookup and commit; every other transaction
// goes through capture, lookup and commit alone. The result sits in an
// output register, so the next transaction is accepted while a finished
// result still waits on out_stall; commit of that next transaction then
// waits until the output register frees up. No clearing pass follows reset:
// the block accepts transactions as soon as reset is released.
module light_slot_cache_top #(
    parameter int NUM_SLOTS     = lsc_pkg::LSC_NUM_SLOTS,
    parameter int LIGHT_ID_BITS = lsc_pkg::LSC_LIGHT_ID_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lsc_pkg::OP_W-1:0]      opcode,
    input  logic [lsc_pkg::LIGHT_W-1:0]   light_number,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lsc_pkg::STATUS_W-1:0]  status,
    output logic [lsc_pkg::SLOT_W-1:0]    slot,
    output logic                          hit,
    output logic                          load_params,
    output logic                          turn_on,
    output logic [lsc_pkg::MASK_W-1:0]    disabled_mask
);
    import lsc_pkg::*;

    lsc_cmd_t  cmd;
    lsc_stat_t stat;

    // Sequencer: capture, lookup, optional age scan, commit
    lsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Slot state, associative compare, age scan and output register
    lsc_dp #(
        .NUM_SLOTS     (NUM_SLOTS),
        .LIGHT_ID_BITS (LIGHT_ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .light_number  (light_number),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .slot          (slot),
        .hit           (hit),
        .load_params   (load_params),
        .turn_on       (turn_on),
        .disabled_mask (disabled_mask)
    );

endmodule

// ===== hdl/lsc_checker.sv =====
module lsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [lsc_pkg::OP_W-1:0]      opcode,
    input logic [lsc_pkg::LIGHT_W-1:0]   light_number,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [lsc_pkg::STATUS_W-1:0]  status,
    input logic [lsc_pkg::SLOT_W-1:0]    slot,
    input logic                          hit,
    input logic                          load_params,
    input logic                          turn_on,
    input logic [lsc_pkg::MASK_W-1:0]    disabled_mask
);
    import lsc_pkg::*;

    // One transaction at a time: an accepted transaction stalls the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(slot)
            && $stable(hit) && $stable(load_params) && $stable(turn_on)
            && $stable(disabled_mask)))
        else $error("stalled result changed");

    // Error results carry no other information
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |->
            (!hit && !load_params && !turn_on && (disabled_mask == '0)
             && (slot == '0)))
        else $error("error result has side fields set");

    // Enable results never switch slots off
    a_enable_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (hit || load_params || turn_on)) |->
            ((status == ST_OK) && (disabled_mask == '0)))
        else $error("enable result with disabled mask");

    // A fresh allocation is always dirty
    a_alloc_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && turn_on && !hit) |-> load_params)
        else $error("allocated slot without parameter load");

endmodule

bind light_slot_cache_top lsc_checker u_lsc_checker (.*);
